FILE: design/mac_pkg.sv
// shared types, codes and character helpers for the mail address classifier
// no dependencies; imported by mac_scan and mail_address_classifier
package mac_pkg;

  // bytes past this count are dropped and the address ends there
  localparam logic [7:0] ADDR_MAX = 8'd255;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_OPEN    = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE   = 8'h29;  // )
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_END     = 8'h00;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_FIDO  = 2'd1,
    CLASS_EMAIL = 2'd2
  } addr_class_t;

  typedef enum logic [3:0] {
    LOC_OPEN        = 4'd0,
    LOC_FIRST_DIGIT = 4'd1,
    LOC_FIRST_NUM   = 4'd2,
    LOC_NET_DIGIT   = 4'd3,
    LOC_NET_NUM     = 4'd4,
    LOC_NODE_DIGIT  = 4'd5,
    LOC_NODE_NUM    = 4'd6,
    LOC_POINT_DIGIT = 4'd7,
    LOC_POINT_NUM   = 4'd8,
    LOC_CLOSED      = 4'd9,
    LOC_FAIL        = 4'd10
  } loc_phase_t;

  typedef enum logic [2:0] {
    EM_LEFT     = 3'd0,
    EM_AFTER_AT = 3'd1,
    EM_RIGHT    = 3'd2,
    EM_CUT      = 3'd3,
    EM_FAIL     = 3'd4
  } em_phase_t;

  typedef struct packed {
    addr_class_t addr_class;
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node;
    logic [15:0] point;
    logic [7:0]  kept;
  } mac_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           is_digit(c) || (c == CH_DASH);
  endfunction

endpackage

FILE: design/mac_scan.sv
// per-byte scanner state for fidonet and email-like address forms
// depends on mac_pkg; result is combinational from the held state
module mac_scan
  import mac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  ch,
  output mac_result_t result
);

  typedef struct packed {
    logic [7:0]  byte_pos;
    logic [7:0]  word_start;
    logic        earlier_names;
    logic        cur_name;
    logic        seen_space;
    loc_phase_t  loc;
    logic [15:0] acc;
    logic        in_digits;
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node;
    logic [15:0] point;
    em_phase_t   em;
    logic [7:0]  cut;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    byte_pos: 8'd0, word_start: 8'd0, earlier_names: 1'b1, cur_name: 1'b1,
    seen_space: 1'b0, loc: LOC_OPEN, acc: 16'd0, in_digits: 1'b0,
    zone: 16'd0, net: 16'd0, node: 16'd0, point: 16'd0,
    em: EM_LEFT, cut: 8'd0
  };

  scan_state_t st;
  scan_state_t st_next;

  logic        dig;
  logic        take;
  logic [15:0] dval;
  logic [15:0] acc_step;

  assign dig      = is_digit(ch);
  assign take     = st.in_digits && dig;
  assign dval     = {12'd0, ch[3:0]};
  assign acc_step = (st.acc << 3) + (st.acc << 1) + dval;

  always_comb begin
    st_next = st;
    if (step) begin
      if (ch == CH_END) begin
        st_next = SCAN_RESET;
      end else if (st.byte_pos < ADDR_MAX) begin
        // email-like form
        unique case (st.em)
          EM_LEFT: begin
            if (ch == CH_AT) begin
              st_next.em = EM_AFTER_AT;
            end else if (ch == CH_SPACE || ch == CH_BANG || ch == CH_DOT ||
                         ch == CH_PERCENT) begin
              st_next.em = EM_FAIL;
            end
          end
          EM_AFTER_AT, EM_RIGHT: begin
            if (ch == CH_SPACE) begin
              st_next.cut = st.byte_pos;
              st_next.em  = EM_CUT;
            end else if (ch == CH_BANG || ch == CH_AT || ch == CH_PERCENT) begin
              st_next.em = EM_FAIL;
            end else begin
              st_next.em = EM_RIGHT;
            end
          end
          default: begin
          end
        endcase

        if (ch == CH_SPACE) begin
          st_next.earlier_names = st.earlier_names && st.cur_name;
          st_next.seen_space    = 1'b1;
          st_next.word_start    = st.byte_pos + 8'd1;
          st_next.cur_name      = 1'b1;
          st_next.loc           = LOC_OPEN;
          st_next.acc           = 16'd0;
          st_next.in_digits     = 1'b0;
          st_next.zone          = 16'd0;
          st_next.net           = 16'd0;
          st_next.node          = 16'd0;
          st_next.point         = 16'd0;
        end else begin
          if (!is_name_char(ch)) st_next.cur_name = 1'b0;
          // last-word location parse
          unique case (st.loc)
            LOC_OPEN: begin
              st_next.loc = (ch == CH_OPEN) ? LOC_FIRST_DIGIT : LOC_FAIL;
            end
            LOC_FIRST_DIGIT, LOC_NET_DIGIT, LOC_NODE_DIGIT, LOC_POINT_DIGIT: begin
              if (dig) begin
                st_next.acc       = dval;
                st_next.in_digits = 1'b1;
                st_next.loc       = loc_phase_t'(st.loc + 4'd1);
              end else begin
                st_next.loc = LOC_FAIL;
              end
            end
            LOC_FIRST_NUM: begin
              if (take) begin
                st_next.acc = acc_step;
              end else begin
                st_next.in_digits = 1'b0;
                if (ch == CH_COLON) begin
                  st_next.zone = st.acc;
                  st_next.loc  = LOC_NET_DIGIT;
                end else if (ch == CH_SLASH) begin
                  st_next.net = st.acc;
                  st_next.loc = LOC_NODE_DIGIT;
                end else if (ch == CH_CLOSE) begin
                  st_next.loc = LOC_FAIL;
                end
              end
            end
            LOC_NET_NUM: begin
              if (take) begin
                st_next.acc = acc_step;
              end else begin
                st_next.in_digits = 1'b0;
                if (ch == CH_SLASH) begin
                  st_next.net = st.acc;
                  st_next.loc = LOC_NODE_DIGIT;
                end else if (ch == CH_CLOSE) begin
                  st_next.loc = LOC_FAIL;
                end
              end
            end
            LOC_NODE_NUM: begin
              if (take) begin
                st_next.acc = acc_step;
              end else begin
                st_next.in_digits = 1'b0;
                if (ch == CH_DOT) begin
                  st_next.node = st.acc;
                  st_next.loc  = LOC_POINT_DIGIT;
                end else if (ch == CH_CLOSE) begin
                  st_next.node = st.acc;
                  st_next.loc  = LOC_CLOSED;
                end
              end
            end
            LOC_POINT_NUM: begin
              if (take) begin
                st_next.acc = acc_step;
              end else begin
                st_next.in_digits = 1'b0;
                if (ch == CH_CLOSE) begin
                  st_next.point = st.acc;
                  st_next.loc   = LOC_CLOSED;
                end
              end
            end
            default: begin
              st_next.loc = LOC_FAIL;
            end
          endcase
        end
        st_next.byte_pos = st.byte_pos + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else begin
      st <= st_next;
    end
  end

  // fidonet wins over email-like
  always_comb begin
    result = '{addr_class: CLASS_NONE, zone: 16'd0, net: 16'd0, node: 16'd0,
               point: 16'd0, kept: 8'd0};
    if (st.seen_space && st.earlier_names && st.loc == LOC_CLOSED) begin
      result.addr_class = CLASS_FIDO;
      result.zone       = st.zone;
      result.net        = st.net;
      result.node       = st.node;
      result.point      = st.point;
      result.kept       = st.word_start - 8'd1;
    end else if (st.em == EM_RIGHT) begin
      result.addr_class = CLASS_EMAIL;
      result.kept       = st.byte_pos;
    end else if (st.em == EM_CUT) begin
      result.addr_class = CLASS_EMAIL;
      result.kept       = st.cut;
    end
  end

endmodule

FILE: design/mail_address_classifier.sv
// top level of the mail address classifier: input register, scanner, result register
// depends on mac_pkg and mac_scan
//
//   channel   signals                                   moves
//   input     in_valid, in_stall, char_in               one address byte per item
//   output    out_valid, out_stall, address_class,      one result per zero byte
//             zone/net/node/point_number, kept_length
//
// one byte per cycle sustained unless a zero byte waits on a stalled result; a byte
// updates the scanner state as it leaves the input register, a zero byte also loads
// the result register, so a result is registered as its zero byte leaves the input
// register; rst is synchronous and returns the scanner to the start of an address
// a waiting result stalls only a following zero byte; other bytes keep flowing
module mail_address_classifier
  import mac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  address_class,
  output logic [15:0] zone_number,
  output logic [15:0] net_number,
  output logic [15:0] node_number,
  output logic [15:0] point_number,
  output logic [7:0]  kept_length
);

  logic        hold_valid;
  logic [7:0]  hold_char;
  logic        out_free;
  logic        advance;
  logic        finish;
  mac_result_t result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && ((hold_char != CH_END) || out_free);
  assign finish   = advance && (hold_char == CH_END);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) hold_char <= char_in;
  end

  mac_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ch     (hold_char),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      address_class <= result.addr_class;
      zone_number   <= result.zone;
      net_number    <= result.net;
      node_number   <= result.node;
      point_number  <= result.point;
      kept_length   <= result.kept;
    end
  end

  // a stall at the input only ever comes from a zero byte behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_char == CH_END && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // numbers are only reported for fidonet addresses
  a_numbers_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && address_class != CLASS_FIDO) |->
      (zone_number == 16'd0 && net_number == 16'd0 &&
       node_number == 16'd0 && point_number == 16'd0))
    else $error("numbers set on a non-fidonet result");

  // an unrecognised address keeps nothing
  a_none_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && address_class == CLASS_NONE) |-> (kept_length == 8'd0))
    else $error("kept length set on an unrecognised result");

  // a finished zero byte always produces a result on the next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("zero byte left no result");

endmodule
